FILE: hdl/sfsa_pkg.sv
package sfsa_pkg;

    localparam int CMD_W    = 2;
    localparam int IDX_W    = 10;
    localparam int STATUS_W = 3;
    localparam int TOTAL_W  = 11;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_CHECK   = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_NOT_LIVE = 3'd1,
        ST_CORRUPT  = 3'd2,
        ST_RANGE    = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // latch the command and issue the memory reads
        logic commit;   // apply the state update and load the result register
    } ctrl_t;

endpackage

FILE: hdl/sfsa_ctrl.sv
module sfsa_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    output sfsa_pkg::ctrl_t ctrl
);

    sfsa_pkg::state_t state_reg;
    sfsa_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sfsa_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        ctrl.accept    = 1'b0;
        ctrl.commit    = 1'b0;
        s_tready       = 1'b0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            sfsa_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    ctrl.accept = 1'b1;
                    state_next  = sfsa_pkg::S_EXEC;
                end
            end
            sfsa_pkg::S_EXEC:
            begin
                // The result register must be empty or draining this cycle.
                if (!out_valid_reg || m_tready)
                begin
                    ctrl.commit    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = sfsa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sfsa_pkg::S_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;

    a_commit_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.commit |=> out_valid_reg)
        else $error("result register not loaded after commit");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !ctrl.commit)
        else $error("pending result overwritten");

    a_exec_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.accept |=> (state_reg == sfsa_pkg::S_EXEC && !s_tready))
        else $error("accepted transaction not executed");

endmodule

FILE: hdl/sfsa_datapath.sv
module sfsa_datapath
#(
    parameter int SLOT_COUNT = 1024
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  sfsa_pkg::ctrl_t               ctrl,
    input  logic [sfsa_pkg::CMD_W-1:0]    in_command,
    input  logic [sfsa_pkg::IDX_W-1:0]    in_slot_index,
    output logic [sfsa_pkg::STATUS_W-1:0] out_status,
    output logic [sfsa_pkg::IDX_W-1:0]    out_granted_slot,
    output logic [sfsa_pkg::TOTAL_W-1:0]  out_removed_total
);

    localparam int AW    = $clog2(SLOT_COUNT);
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam int FW    = sfsa_pkg::IDX_W;
    localparam logic [CNT_W-1:0] NO_SLOT = CNT_W'(SLOT_COUNT);

    // Removed flags and stack links, one entry per slot; never cleared.
    logic             flag_mem [SLOT_COUNT];
    logic [CNT_W-1:0] link_mem [SLOT_COUNT];

    logic             flag_rd_reg;
    logic [CNT_W-1:0] link_rd_reg;

    logic [CNT_W-1:0] top_reg;
    logic [CNT_W-1:0] top_next;
    logic [CNT_W-1:0] unused_reg;
    logic [CNT_W-1:0] unused_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic [sfsa_pkg::CMD_W-1:0] cmd_reg;
    logic [FW-1:0]              idx_reg;

    logic [sfsa_pkg::STATUS_W-1:0] status_reg;
    logic [FW-1:0]                 granted_reg;
    logic [sfsa_pkg::TOTAL_W-1:0]  total_reg;

    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    idx_addr;
    logic [AW-1:0]    top_addr;
    logic [AW-1:0]    unused_addr;
    logic [AW+FW-1:0] in_idx_ext;
    logic [AW+FW-1:0] idx_ext;
    logic             idx_in_range;

    logic             flag_we;
    logic [AW-1:0]    flag_waddr;
    logic             flag_wdata;
    logic             link_we;
    logic [AW-1:0]    link_waddr;
    logic [CNT_W-1:0] link_wdata;

    logic [sfsa_pkg::STATUS_W-1:0] status_next;
    logic [FW-1:0]                 granted_next;
    logic [CNT_W+FW-1:0]           top_wide;
    logic [CNT_W+FW-1:0]           unused_wide;
    logic [CNT_W+FW-1:0]           idx_wide;
    logic [CNT_W+sfsa_pkg::TOTAL_W-1:0] count_wide;

    assign in_idx_ext  = {{AW{1'b0}}, in_slot_index};
    assign idx_ext     = {{AW{1'b0}}, idx_reg};
    assign idx_addr    = idx_ext[AW-1:0];
    assign top_addr    = top_reg[AW-1:0];
    assign unused_addr = unused_reg[AW-1:0];

    // Allocate inspects the stack top, release and check inspect the slot given.
    assign rd_addr = (in_command == sfsa_pkg::CMD_ALLOC) ? top_addr : in_idx_ext[AW-1:0];

    assign top_wide     = {{FW{1'b0}}, top_reg};
    assign unused_wide  = {{FW{1'b0}}, unused_reg};
    assign idx_wide     = {{CNT_W{1'b0}}, idx_reg};
    assign idx_in_range = idx_wide < unused_wide;

    always_ff @(posedge clk)
    begin
        if (flag_we)
        begin
            flag_mem[flag_waddr] <= flag_wdata;
        end
        if (ctrl.accept)
        begin
            flag_rd_reg <= flag_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (ctrl.accept)
        begin
            link_rd_reg <= link_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            cmd_reg <= in_command;
            idx_reg <= in_slot_index;
        end
        if (ctrl.commit)
        begin
            status_reg  <= status_next;
            granted_reg <= granted_next;
            total_reg   <= (count_wide > {{CNT_W{1'b0}}, sfsa_pkg::TOTAL_MAX})
                           ? sfsa_pkg::TOTAL_MAX : count_wide[sfsa_pkg::TOTAL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg    <= NO_SLOT;
            unused_reg <= '0;
            count_reg  <= '0;
        end
        else if (ctrl.commit)
        begin
            top_reg    <= top_next;
            unused_reg <= unused_next;
            count_reg  <= count_next;
        end
    end

    assign count_wide = {{sfsa_pkg::TOTAL_W{1'b0}}, count_next};

    always_comb
    begin
        top_next     = top_reg;
        unused_next  = unused_reg;
        count_next   = count_reg;
        status_next  = sfsa_pkg::ST_OK;
        granted_next = idx_reg;
        flag_we      = 1'b0;
        flag_waddr   = idx_addr;
        flag_wdata   = 1'b0;
        link_we      = 1'b0;
        link_waddr   = idx_addr;
        link_wdata   = '0;

        case (cmd_reg)
            sfsa_pkg::CMD_ALLOC:
            begin
                granted_next = '0;
                if (top_reg != NO_SLOT)
                begin
                    if (!flag_rd_reg)
                    begin
                        status_next = sfsa_pkg::ST_CORRUPT;
                    end
                    else
                    begin
                        top_next     = (link_rd_reg < NO_SLOT) ? link_rd_reg : NO_SLOT;
                        count_next   = (count_reg != '0) ? count_reg - 1'b1 : count_reg;
                        flag_we      = ctrl.commit;
                        flag_waddr   = top_addr;
                        granted_next = top_wide[FW-1:0];
                    end
                end
                else if (unused_reg == NO_SLOT)
                begin
                    status_next = sfsa_pkg::ST_FULL;
                end
                else
                begin
                    granted_next = unused_wide[FW-1:0];
                    flag_we      = ctrl.commit;
                    flag_waddr   = unused_addr;
                    link_we      = ctrl.commit;
                    link_waddr   = unused_addr;
                    unused_next  = unused_reg + 1'b1;
                end
            end
            sfsa_pkg::CMD_RELEASE:
            begin
                if (!idx_in_range)
                begin
                    status_next = sfsa_pkg::ST_RANGE;
                end
                else if (flag_rd_reg)
                begin
                    status_next = sfsa_pkg::ST_NOT_LIVE;
                end
                else
                begin
                    flag_we    = ctrl.commit;
                    flag_wdata = 1'b1;
                    link_we    = ctrl.commit;
                    link_wdata = top_reg;
                    top_next   = idx_wide[CNT_W-1:0];
                    count_next = count_reg + 1'b1;
                end
            end
            sfsa_pkg::CMD_CHECK:
            begin
                if (!idx_in_range)
                begin
                    status_next = sfsa_pkg::ST_RANGE;
                end
                else if (flag_rd_reg)
                begin
                    status_next = sfsa_pkg::ST_NOT_LIVE;
                end
            end
            default:
            begin
                status_next = sfsa_pkg::ST_RANGE;
            end
        endcase
    end

    assign out_status        = status_reg;
    assign out_granted_slot  = granted_reg;
    assign out_removed_total = total_reg;

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= unused_reg)
        else $error("removed count exceeds slots in use");

    a_unused_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        unused_reg <= NO_SLOT)
        else $error("next unused slot beyond the end");

    a_empty_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        (top_reg == NO_SLOT) == (count_reg == '0))
        else $error("stack emptiness and removed count disagree");

endmodule

FILE: hdl/slot_free_stack_allocator_top.sv
// A transaction is accepted in the idle state and executed in the execute state; its result is then held on m_tdata.
// A new command is accepted only after the last one has executed; the synchronous read of the removed-flag
// and link memories must finish before the new stack top and the status are known.
// A result may wait in the output register while the next command is accepted.
// Reset (rst_n low, asynchronous) empties the stack and zeroes the unused-slot and
// removed counters; the slot memories are not cleared, and no clearing pass runs.
module slot_free_stack_allocator_top
#(
    parameter int SLOT_COUNT = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [1:0] command, [11:2] slot_index, [15:12] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [2:0] status, [12:3] granted_slot, [23:13] removed_total
);

    // The controller sequences each transaction through two steps: in the
    // accept cycle the command is captured and the flag and link memories are
    // read (at the stack top for allocate, at the given slot otherwise); in
    // the execute state, once the result register is free, the datapath decides the status,
    // writes the memories, updates the stack top and counters, and loads the output register.
    sfsa_pkg::ctrl_t ctrl;

    logic [sfsa_pkg::STATUS_W-1:0] status;
    logic [sfsa_pkg::IDX_W-1:0]    granted_slot;
    logic [sfsa_pkg::TOTAL_W-1:0]  removed_total;

    sfsa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctrl     (ctrl)
    );

    // The datapath holds the slot memories, the stack top, the next never-used
    // slot, the removed count and the result register.
    sfsa_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .ctrl              (ctrl),
        .in_command        (s_tdata[1:0]),
        .in_slot_index     (s_tdata[11:2]),
        .out_status        (status),
        .out_granted_slot  (granted_slot),
        .out_removed_total (removed_total)
    );

    // Fields packed from the lowest bit up; the 24-bit word is already full.
    assign m_tdata = {removed_total, granted_slot, status};

endmodule
